@@ rtl/pps_pkg.sv @@
// types, constants and sizes shared by the preemptive priority scheduler
`default_nettype none

package pps_pkg;

   // ready table depth and derived widths
   localparam int QUEUE_DEPTH = 16;
   localparam int QIDX_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

   // field widths
   localparam int TIME_W = 32;
   localparam int ID_W   = 16;
   localparam int BURST_W = 16;
   localparam int PRI_W  = 8;
   localparam int WCNT_W = 5;

   // stream widths
   localparam int REQ_DATA_W  = 104;
   localparam int REQ_USER_W  = 1;
   localparam int RSP_DATA_W  = 160;
   localparam int RSP_USER_W  = 2;

   // request kinds
   localparam logic FUNC_ARRIVAL = 1'b0;
   localparam logic FUNC_DONE    = 1'b1;

   // one process record, as held in the ready table
   typedef struct packed {
      logic [ID_W-1:0]    id;
      logic [TIME_W-1:0]  arrival;
      logic [BURST_W-1:0] total;
      logic [BURST_W-1:0] remaining;
      logic [PRI_W-1:0]   prio;
   } proc_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EXEC,
      ST_SCAN,
      ST_COMMIT,
      ST_RESP
   } state_type;

endpackage

`default_nettype wire

@@ rtl/preemptive_priority_scheduler.sv @@
// preemptive priority scheduler: running record, ready table and scan sequencer
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+------------------------------------------
//  req     | in        | req_tvalid/tready  | tuser: func; tdata: event and new process
//  rsp     | out       | rsp_tvalid/tready  | tuser: run_valid, dropped; tdata: record
//
// an arrival or a completion on an empty table passes from acceptance through the
// execute state to the response state (accept, execute, respond)
// a completion with entries waiting reads the ready table once per entry through a
// single read port in the scan state, then refills the chosen slot in the commit state
// before it offers its response (a full table holds 16 entries)
// reset clears the running record and the table fill count; table contents
// stay unknown until written and only entries below the fill count are read
// one request at a time: req_tready is low from acceptance until the response is taken
`default_nettype none

module preemptive_priority_scheduler
   import pps_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,

   input  wire logic                  req_tvalid,
   output      logic                  req_tready,
   // now_time[31:0], new_id[47:32], new_arrival[79:48], new_burst[95:80],
   // new_priority[103:96]
   input  wire logic [REQ_DATA_W-1:0] req_tdata,
   // func[0]
   input  wire logic [REQ_USER_W-1:0] req_tuser,

   output      logic                  rsp_tvalid,
   input  wire logic                  rsp_tready,
   // run_id[15:0], run_arrival[47:16], run_total[63:48], run_remaining[79:64],
   // run_start[111:80], run_end[143:112], run_priority[151:144],
   // waiting_count[156:152], zero fill[159:157]
   output      logic [RSP_DATA_W-1:0] rsp_tdata,
   // run_valid[0], dropped[1]
   output      logic [RSP_USER_W-1:0] rsp_tuser
);

   // sequencer
   state_type state_ff, state_in;

   // latched request
   logic              func_ff, func_in;
   logic [TIME_W-1:0] now_ff, now_in;
   proc_type          new_ff, new_in;

   // running record
   logic              run_valid_ff, run_valid_in;
   proc_type          run_ff, run_in;
   logic [TIME_W-1:0] run_start_ff, run_start_in;
   logic [TIME_W-1:0] run_end_ff, run_end_in;

   // table bookkeeping
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              dropped_ff, dropped_in;

   // scan datapath
   logic [CNT_W-1:0]  scan_idx_ff, scan_idx_in;
   logic              rd_valid_ff, rd_valid_in;
   logic [QIDX_W-1:0] rd_idx_ff, rd_idx_in;
   logic [QIDX_W-1:0] best_idx_ff, best_idx_in;
   proc_type          best_ff, best_in;
   proc_type          last_ff, last_in;

   // ready table memory, one write and one registered read port
   proc_type          mem_ff [QUEUE_DEPTH];
   proc_type          rd_data_ff;
   logic [QIDX_W-1:0] rd_addr;
   logic              mem_we;
   logic [QIDX_W-1:0] mem_waddr;
   proc_type          mem_wdata;

   // helpers
   logic [QIDX_W-1:0] last_idx;
   logic [TIME_W-1:0] time_diff;
   logic [BURST_W-1:0] preempt_rem;
   logic              table_full;

   assign last_idx   = QIDX_W'(count_ff - CNT_W'(1));
   assign table_full = (count_ff >= CNT_W'(QUEUE_DEPTH));
   assign time_diff  = run_end_ff - now_ff;

   // time left for a preempted process, clamped at zero and saturated
   always_comb begin
      if (run_end_ff > now_ff) begin
         preempt_rem = (time_diff[TIME_W-1:BURST_W] != '0) ? '1 : time_diff[BURST_W-1:0];
      end else begin
         preempt_rem = '0;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (func_ff == FUNC_DONE && count_ff != '0) begin
               state_in = ST_SCAN;
            end else begin
               state_in = ST_RESP;
            end
         end
         ST_SCAN: begin
            if (rd_valid_ff && rd_idx_ff == last_idx) begin
               state_in = ST_COMMIT;
            end
         end
         ST_COMMIT: begin
            state_in = ST_RESP;
         end
         ST_RESP: begin
            if (rsp_tready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // datapath and outputs
   always_comb begin
      func_in      = func_ff;
      now_in       = now_ff;
      new_in       = new_ff;
      run_valid_in = run_valid_ff;
      run_in       = run_ff;
      run_start_in = run_start_ff;
      run_end_in   = run_end_ff;
      count_in     = count_ff;
      dropped_in   = dropped_ff;
      scan_idx_in  = scan_idx_ff;
      rd_valid_in  = 1'b0;
      rd_idx_in    = rd_idx_ff;
      best_idx_in  = best_idx_ff;
      best_in      = best_ff;
      last_in      = last_ff;
      rd_addr      = scan_idx_ff[QIDX_W-1:0];
      mem_we       = 1'b0;
      mem_waddr    = count_ff[QIDX_W-1:0];
      mem_wdata    = new_ff;
      req_tready   = 1'b0;
      rsp_tvalid   = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               func_in            = req_tuser[0];
               now_in             = req_tdata[31:0];
               new_in.id          = req_tdata[47:32];
               new_in.arrival     = req_tdata[79:48];
               new_in.total       = req_tdata[95:80];
               new_in.remaining   = req_tdata[95:80];
               new_in.prio        = req_tdata[103:96];
               dropped_in         = 1'b0;
            end
         end
         ST_EXEC: begin
            scan_idx_in = '0;
            if (func_ff == FUNC_ARRIVAL) begin
               priority if (!run_valid_ff) begin
                  run_valid_in = 1'b1;
                  run_in       = new_ff;
                  run_start_in = now_ff;
                  run_end_in   = now_ff + TIME_W'(new_ff.remaining);
               end else if (table_full) begin
                  dropped_in = 1'b1;
               end else if (new_ff.prio < run_ff.prio) begin
                  // preempt: park the running process at the table tail
                  mem_we              = 1'b1;
                  mem_wdata           = run_ff;
                  mem_wdata.remaining = preempt_rem;
                  count_in            = count_ff + CNT_W'(1);
                  run_in              = new_ff;
                  run_start_in        = now_ff;
                  run_end_in          = now_ff + TIME_W'(new_ff.remaining);
               end else begin
                  mem_we   = 1'b1;
                  count_in = count_ff + CNT_W'(1);
               end
            end else if (count_ff == '0) begin
               // nothing waiting: go idle with a null record
               run_valid_in = 1'b0;
               run_in       = '0;
               run_start_in = '0;
               run_end_in   = '0;
            end
         end
         ST_SCAN: begin
            // issue one table read per cycle
            if (scan_idx_ff < count_ff) begin
               rd_valid_in = 1'b1;
               rd_idx_in   = scan_idx_ff[QIDX_W-1:0];
               scan_idx_in = scan_idx_ff + CNT_W'(1);
            end
            // compare the entry read last cycle, first index wins ties
            if (rd_valid_ff) begin
               if (rd_idx_ff == '0 || rd_data_ff.prio < best_ff.prio) begin
                  best_idx_in = rd_idx_ff;
                  best_in     = rd_data_ff;
               end
               if (rd_idx_ff == last_idx) begin
                  last_in = rd_data_ff;
               end
            end
         end
         ST_COMMIT: begin
            // last entry fills the hole left by the chosen one
            mem_we       = 1'b1;
            mem_waddr    = best_idx_ff;
            mem_wdata    = last_ff;
            count_in     = count_ff - CNT_W'(1);
            run_valid_in = 1'b1;
            run_in       = best_ff;
            run_start_in = now_ff;
            run_end_in   = now_ff + TIME_W'(best_ff.remaining);
         end
         ST_RESP: begin
            rsp_tvalid = 1'b1;
         end
         default: begin
         end
      endcase
   end

   // response payload straight from the running record, the fill count and the drop flag
   assign rsp_tdata = {3'b000,
                       WCNT_W'(count_ff),
                       run_ff.prio,
                       run_end_ff,
                       run_start_ff,
                       run_ff.remaining,
                       run_ff.total,
                       run_ff.arrival,
                       run_ff.id};
   assign rsp_tuser = {dropped_ff, run_valid_ff};

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         run_valid_ff <= 1'b0;
         run_ff       <= '0;
         run_start_ff <= '0;
         run_end_ff   <= '0;
         count_ff     <= '0;
         dropped_ff   <= 1'b0;
         rd_valid_ff  <= 1'b0;
      end else begin
         state_ff     <= state_in;
         run_valid_ff <= run_valid_in;
         run_ff       <= run_in;
         run_start_ff <= run_start_in;
         run_end_ff   <= run_end_in;
         count_ff     <= count_in;
         dropped_ff   <= dropped_in;
         rd_valid_ff  <= rd_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      func_ff     <= func_in;
      now_ff      <= now_in;
      new_ff      <= new_in;
      scan_idx_ff <= scan_idx_in;
      rd_idx_ff   <= rd_idx_in;
      best_idx_ff <= best_idx_in;
      best_ff     <= best_in;
      last_ff     <= last_in;
   end

   // ready table
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem_ff[mem_waddr] <= mem_wdata;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

endmodule

`default_nettype wire

@@ tb/preemptive_priority_scheduler_tb.sv @@
// testbench for the preemptive priority scheduler: directed and random event streams
module preemptive_priority_scheduler_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import pps_pkg::*;

   localparam int RANDOM_EVENTS = 450;
   localparam int DRAIN_CYCLES  = 40;

   // one scheduler event as it travels on the request channel
   typedef struct packed {
      logic               func;
      logic [TIME_W-1:0]  now_time;
      logic [ID_W-1:0]    new_id;
      logic [TIME_W-1:0]  new_arrival;
      logic [BURST_W-1:0] new_burst;
      logic [PRI_W-1:0]   new_prio;
   } sched_event_t;

   // running record reported after each event
   typedef struct packed {
      logic               run_valid;
      logic [ID_W-1:0]    run_id;
      logic [TIME_W-1:0]  run_arrival;
      logic [BURST_W-1:0] run_total;
      logic [BURST_W-1:0] run_remaining;
      logic [TIME_W-1:0]  run_start;
      logic [TIME_W-1:0]  run_end;
      logic [PRI_W-1:0]   run_prio;
      logic [WCNT_W-1:0]  waiting_count;
      logic               dropped;
   } run_record_t;

   // one waiting process in the ready table
   typedef struct packed {
      logic [ID_W-1:0]    id;
      logic [TIME_W-1:0]  arrival;
      logic [BURST_W-1:0] total;
      logic [BURST_W-1:0] remaining;
      logic [PRI_W-1:0]   prio;
   } ready_entry_t;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic [REQ_USER_W-1:0] req_tuser = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic [RSP_USER_W-1:0] rsp_tuser;

   preemptive_priority_scheduler dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // stimulus and expectations
   sched_event_t pending_events[$];
   run_record_t  predicted_records[$];
   int           events_total;
   int           events_sent;
   int           mismatches;

   // shadow scheduler state
   logic               cur_busy;
   ready_entry_t       cur_proc;
   logic [TIME_W-1:0]  cur_start;
   logic [TIME_W-1:0]  cur_end;
   ready_entry_t       ready_tbl[QUEUE_DEPTH];
   int                 ready_cnt;

   // what the run went through
   int n_arrivals, n_completions, n_preempts, n_drops, n_empty_done, n_full_seen;

   // start a process now, remaining time is its whole burst
   function automatic void launch(input sched_event_t ev);
      cur_busy           = 1'b1;
      cur_proc.id        = ev.new_id;
      cur_proc.arrival   = ev.new_arrival;
      cur_proc.total     = ev.new_burst;
      cur_proc.remaining = ev.new_burst;
      cur_proc.prio      = ev.new_prio;
      cur_start          = ev.now_time;
      cur_end            = ev.now_time + TIME_W'(ev.new_burst);
   endfunction

   function automatic void enqueue(input ready_entry_t e);
      ready_tbl[ready_cnt] = e;
      ready_cnt++;
   endfunction

   // advance the shadow scheduler by one event and return the record it reports
   function automatic run_record_t schedule_event(input sched_event_t ev);
      run_record_t       rec;
      ready_entry_t      fresh;
      ready_entry_t      evicted;
      logic [TIME_W-1:0] left;
      logic              drop;
      int                best;
      drop = 1'b0;
      if (ev.func == FUNC_ARRIVAL) begin
         n_arrivals++;
         if (!cur_busy) begin
            launch(ev);
         end else if (ready_cnt >= QUEUE_DEPTH) begin
            // table full: lost whether it would queue or preempt
            drop = 1'b1;
            n_drops++;
         end else if (ev.new_prio < cur_proc.prio) begin
            // strictly more urgent: the running process goes back with what is left
            left = '0;
            if (cur_end > ev.now_time) begin
               left = cur_end - ev.now_time;
               if (left > 32'h0000_FFFF) begin
                  left = 32'h0000_FFFF;
               end
            end
            evicted           = cur_proc;
            evicted.remaining = left[BURST_W-1:0];
            enqueue(evicted);
            launch(ev);
            n_preempts++;
         end else begin
            fresh.id        = ev.new_id;
            fresh.arrival   = ev.new_arrival;
            fresh.total     = ev.new_burst;
            fresh.remaining = ev.new_burst;
            fresh.prio      = ev.new_prio;
            enqueue(fresh);
         end
         if (ready_cnt == QUEUE_DEPTH) begin
            n_full_seen++;
         end
      end else begin
         n_completions++;
         if (ready_cnt == 0) begin
            // nothing waiting: go idle with the null record
            cur_busy  = 1'b0;
            cur_proc  = '0;
            cur_start = '0;
            cur_end   = '0;
            n_empty_done++;
         end else begin
            // most urgent entry, first index wins a tie
            best = 0;
            for (int i = 1; i < ready_cnt; i++) begin
               if (ready_tbl[i].prio < ready_tbl[best].prio) begin
                  best = i;
               end
            end
            cur_busy        = 1'b1;
            cur_proc        = ready_tbl[best];
            cur_start       = ev.now_time;
            cur_end         = ev.now_time + TIME_W'(cur_proc.remaining);
            // last entry fills the hole
            ready_tbl[best] = ready_tbl[ready_cnt-1];
            ready_cnt--;
         end
      end
      rec.run_valid     = cur_busy;
      rec.run_id        = cur_proc.id;
      rec.run_arrival   = cur_proc.arrival;
      rec.run_total     = cur_proc.total;
      rec.run_remaining = cur_proc.remaining;
      rec.run_start     = cur_start;
      rec.run_end       = cur_end;
      rec.run_prio      = cur_proc.prio;
      rec.waiting_count = WCNT_W'(ready_cnt);
      rec.dropped       = drop;
      return rec;
   endfunction

   function automatic void compare_field(input string name, input logic [TIME_W-1:0] want,
                                         input logic [TIME_W-1:0] got);
      if (got !== want) begin
         $error("%s mismatch: expected %0h, got %0h", name, want, got);
         mismatches++;
      end
   endfunction

   // per-request wait, with calm stretches where a side never idles
   bit req_calm, rsp_calm;

   function automatic int draw_wait(inout bit calm);
      if ($urandom_range(0, 39) == 0) begin
         calm = !calm;
      end
      return calm ? 0 : $urandom_range(0, 4);
   endfunction

   // driver: one request in flight, the block holds req_tready low until it answers
   sched_event_t req_cur;
   int           req_wait;

   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         req_wait = 0;
      end else if (req_tvalid && req_tready) begin
         // request taken: predict now, then decide on the next one
         predicted_records.push_back(schedule_event(req_cur));
         events_sent++;
         req_wait = draw_wait(req_calm);
         if (req_wait == 0 && pending_events.size() != 0) begin
            req_cur = pending_events.pop_front();
            req_tdata <= {req_cur.new_prio, req_cur.new_burst, req_cur.new_arrival,
                          req_cur.new_id, req_cur.now_time};
            req_tuser <= req_cur.func;
         end else begin
            req_tvalid <= 1'b0;
         end
      end else if (!req_tvalid) begin
         if (req_wait > 0) begin
            req_wait--;
         end else if (pending_events.size() != 0) begin
            req_cur = pending_events.pop_front();
            req_tdata <= {req_cur.new_prio, req_cur.new_burst, req_cur.new_arrival,
                          req_cur.new_id, req_cur.now_time};
            req_tuser <= req_cur.func;
            req_tvalid <= 1'b1;
         end
      end
   end

   // monitor: takes each record and checks it against the oldest prediction
   int          rsp_wait;
   run_record_t rsp_want;

   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         rsp_wait = 0;
      end else if (rsp_tvalid && rsp_tready) begin
         if (predicted_records.size() == 0) begin
            $error("record with no request outstanding: tdata %0h tuser %0h",
                   rsp_tdata, rsp_tuser);
            mismatches++;
         end else begin
            rsp_want = predicted_records.pop_front();
            compare_field("run_valid", TIME_W'(rsp_want.run_valid), TIME_W'(rsp_tuser[0]));
            compare_field("dropped", TIME_W'(rsp_want.dropped), TIME_W'(rsp_tuser[1]));
            compare_field("run_id", TIME_W'(rsp_want.run_id), TIME_W'(rsp_tdata[15:0]));
            compare_field("run_arrival", rsp_want.run_arrival, rsp_tdata[47:16]);
            compare_field("run_total", TIME_W'(rsp_want.run_total), TIME_W'(rsp_tdata[63:48]));
            compare_field("run_remaining", TIME_W'(rsp_want.run_remaining),
                          TIME_W'(rsp_tdata[79:64]));
            compare_field("run_start", rsp_want.run_start, rsp_tdata[111:80]);
            compare_field("run_end", rsp_want.run_end, rsp_tdata[143:112]);
            compare_field("run_priority", TIME_W'(rsp_want.run_prio),
                          TIME_W'(rsp_tdata[151:144]));
            compare_field("waiting_count", TIME_W'(rsp_want.waiting_count),
                          TIME_W'(rsp_tdata[156:152]));
         end
         rsp_wait = draw_wait(rsp_calm);
         rsp_tready <= (rsp_wait == 0);
      end else if (!rsp_tready) begin
         if (rsp_wait > 0) begin
            rsp_wait--;
         end
         if (rsp_wait == 0) begin
            rsp_tready <= 1'b1;
         end
      end
   end

   function automatic void add_event(input logic func, input logic [TIME_W-1:0] now_time,
                                     input logic [ID_W-1:0] id,
                                     input logic [TIME_W-1:0] arrival,
                                     input logic [BURST_W-1:0] burst,
                                     input logic [PRI_W-1:0] prio);
      sched_event_t ev;
      ev.func        = func;
      ev.now_time    = now_time;
      ev.new_id      = id;
      ev.new_arrival = arrival;
      ev.new_burst   = burst;
      ev.new_prio    = prio;
      pending_events.push_back(ev);
   endfunction

   // hard stop in case the block hangs
   initial begin
      #2_000_000;
      $display("Test completed with failures");
      $finish;
   end

   initial begin
      int                 made;
      int                 seg_len;
      int                 arr_pct;
      logic               func;
      logic [TIME_W-1:0]  stamp;
      logic [TIME_W-1:0]  arrival;
      logic [BURST_W-1:0] burst;
      logic [PRI_W-1:0]   prio;

      cur_busy  = 1'b0;
      cur_proc  = '0;
      cur_start = '0;
      cur_end   = '0;
      ready_cnt = 0;

      // directed: completion while idle gives the null record
      add_event(FUNC_DONE, 32'd5, 16'd9, 32'd0, 16'd3, 8'd4);
      // arrival while idle, end wraps past the top of time, all-ones fields
      add_event(FUNC_ARRIVAL, 32'hFFFF_FFF0, 16'hFFFF, 32'hFFFF_FFFF, 16'hFFFF, 8'h80);
      // equal priority queues, no preemption
      add_event(FUNC_ARRIVAL, 32'hFFFF_FFF1, 16'd2, 32'hFFFF_FFF1, 16'd10, 8'h80);
      // preempt with time left on the running process
      add_event(FUNC_ARRIVAL, 32'd8, 16'd3, 32'd8, 16'd0, 8'h10);
      // preempt after the running process should have ended, nothing left
      add_event(FUNC_ARRIVAL, 32'h0002_0000, 16'd4, 32'h0002_0000, 16'd5, 8'h00);
      // least urgent possible, queued
      add_event(FUNC_ARRIVAL, 32'd0, 16'd5, 32'd0, 16'd0, 8'hFF);
      // completions: lowest priority number, then first index on a tie
      add_event(FUNC_DONE, 32'h100, 16'd0, 32'd0, 16'd0, 8'd0);
      add_event(FUNC_DONE, 32'h200, 16'hAAAA, 32'h5555_5555, 16'h5555, 8'hAA);
      // preempt where the remaining time saturates, time going backwards
      add_event(FUNC_ARRIVAL, 32'h1000_0000, 16'd6, 32'h1000_0000, 16'd100, 8'h05);
      add_event(FUNC_ARRIVAL, 32'd0, 16'd7, 32'd0, 16'd1, 8'h01);
      // drain through to an empty table and two null completions
      add_event(FUNC_DONE, 32'h300, 16'd0, 32'd0, 16'd0, 8'd0);
      add_event(FUNC_DONE, 32'h400, 16'd0, 32'd0, 16'd0, 8'd0);
      add_event(FUNC_DONE, 32'h500, 16'd0, 32'd0, 16'd0, 8'd0);
      add_event(FUNC_DONE, 32'h600, 16'd0, 32'd0, 16'd0, 8'd0);
      add_event(FUNC_DONE, 32'h700, 16'd0, 32'd0, 16'd0, 8'd0);
      add_event(FUNC_DONE, 32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF, 16'hFFFF, 8'hFF);
      // all-zero arrival while idle, then an equal-priority zero queues behind it
      add_event(FUNC_ARRIVAL, 32'd0, 16'd1, 32'd0, 16'd0, 8'd0);
      add_event(FUNC_ARRIVAL, 32'd1, 16'd1, 32'd0, 16'hFFFF, 8'd0);
      add_event(FUNC_DONE, 32'd2, 16'd0, 32'd0, 16'd0, 8'd0);

      // random: segments that lean toward arrivals (fill and overflow), toward completions, or are balanced
      stamp = $urandom;
      made  = 0;
      while (made < RANDOM_EVENTS) begin
         seg_len = $urandom_range(5, 40);
         case ($urandom_range(0, 2))
            0: begin
               arr_pct = 90;
            end
            1: begin
               arr_pct = 55;
            end
            default: begin
               arr_pct = 15;
            end
         endcase
         repeat (seg_len) begin
            func = ($urandom_range(1, 100) <= arr_pct) ? FUNC_ARRIVAL : FUNC_DONE;
            // time mostly moves forward, now and then jumps anywhere
            if ($urandom_range(0, 19) == 0) begin
               stamp = $urandom;
            end else begin
               stamp = stamp + $urandom_range(0, 300);
            end
            arrival = $urandom_range(0, 1) ? stamp - $urandom_range(0, 50) : $urandom;
            case ($urandom_range(0, 3))
               0: begin
                  burst = BURST_W'($urandom_range(0, 50));
               end
               1: begin
                  burst = BURST_W'($urandom_range(0, 1000));
               end
               2: begin
                  burst = BURST_W'($urandom_range(0, 65535));
               end
               default: begin
                  burst = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
               end
            endcase
            // narrow priorities give plenty of ties and preemptions
            case ($urandom_range(0, 9))
               0: begin
                  prio = $urandom_range(0, 1) ? 8'hFF : 8'h00;
               end
               1, 2, 3: begin
                  prio = PRI_W'($urandom_range(0, 255));
               end
               default: begin
                  prio = PRI_W'($urandom_range(0, 7));
               end
            endcase
            add_event(func, stamp, ID_W'($urandom_range(1, 65535)), arrival, burst, prio);
            made++;
         end
      end
      events_total = pending_events.size();

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // wait for every request to be taken and every record checked
      while (events_sent != events_total || predicted_records.size() != 0) begin
         @(posedge clock);
      end
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("ran %0d events: %0d arrivals with %0d preemptions and %0d drops,",
               events_sent, n_arrivals, n_preempts, n_drops);
      $display("%0d completions (%0d on an empty table), full table reached %0d times",
               n_completions, n_empty_done, n_full_seen);
      if (mismatches == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
